/* design/kway_merge_min_heap_assert.svh */
// Assertion macros for the k-way merge heap.
// Clocked on i_clk, disabled while i_rst_n is low; no dependencies.
`ifndef KWAY_MERGE_MIN_HEAP_ASSERT_SVH
`define KWAY_MERGE_MIN_HEAP_ASSERT_SVH

// condition must hold at every edge out of reset
`define KMH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold at the same edge as the antecedent
`define KMH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/kmh_pkg.sv */
// Shared constants and types for the k-way merge heap.
// No dependencies.
`default_nettype none

package kmh_pkg;

    typedef logic [1:0] t_op;

    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_REPL = 2'd2;

    localparam int LIST_BITS   = 4;
    localparam int RESULT_BITS = 32;

endpackage

`default_nettype wire

/* design/kmh_mem.sv */
// Heap storage: one write port, two read ports, registered read data.
// Depends on nothing; entry layout is set by the user.
`default_nettype none

module kmh_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 36
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

/* design/kmh_order.sv */
// Entry ordering: signed value first, smaller list number on a tie.
// Uses kmh_pkg for the list number width.
`default_nettype none

module kmh_order #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic [VALUE_BITS-1:0]        i_a_value,
    input  wire logic [kmh_pkg::LIST_BITS-1:0] i_a_list,
    input  wire logic [VALUE_BITS-1:0]        i_b_value,
    input  wire logic [kmh_pkg::LIST_BITS-1:0] i_b_list,
    output logic                              o_a_first
);

    always_comb begin
        if (i_a_value != i_b_value) begin
            o_a_first = $signed(i_a_value) < $signed(i_b_value);
        end else begin
            o_a_first = i_a_list < i_b_list;
        end
    end

endmodule

`default_nettype wire

/* design/kway_merge_min_heap.sv */
// k-way merge min-heap, one operation in work at a time. Push: S_PUSH, then S_SU_RD and
// S_SU_CMP per parent compared, S_PUT when it rises to the root, then S_DONE; straight to S_DONE
// when full. Pop: S_POP_RD, S_POP_LD, then S_SD_RD and S_SD_CMP per sift-down level; straight
// to S_DONE when empty. Replace runs the pop part, then the push. The next transfer can be taken
// in the cycle after the result register loads; each level is a memory read, then a compare and
// write. Synchronous active-low reset empties the heap; storage is not cleared.
`default_nettype none

module kway_merge_min_heap #(
    parameter int LISTS      = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [1:0]                       i_op,
    input  wire logic signed [VALUE_BITS-1:0]     i_value,
    input  wire logic [kmh_pkg::LIST_BITS-1:0]    i_list_id,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [kmh_pkg::RESULT_BITS-1:0] o_min_value,
    output logic [kmh_pkg::LIST_BITS-1:0]         o_min_list,
    output logic                                  o_was_empty,
    output logic                                  o_overflow,
    output logic [$clog2(LISTS+1)-1:0]            o_count
);

    `include "kway_merge_min_heap_assert.svh"

    localparam int LB = kmh_pkg::LIST_BITS;
    localparam int IW = $clog2(LISTS);
    localparam int CW = $clog2(LISTS + 1);
    localparam int XW = IW + 2;
    localparam int EW = VALUE_BITS + LB;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP_RD = 4'd1;
    localparam logic [3:0] S_POP_LD = 4'd2;
    localparam logic [3:0] S_SD_RD  = 4'd3;
    localparam logic [3:0] S_SD_CMP = 4'd4;
    localparam logic [3:0] S_PUSH   = 4'd5;
    localparam logic [3:0] S_SU_RD  = 4'd6;
    localparam logic [3:0] S_SU_CMP = 4'd7;
    localparam logic [3:0] S_PUT    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]            r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    kmh_pkg::t_op          r_op, n_op;
    logic [VALUE_BITS-1:0] r_in_val, n_in_val;
    logic [LB-1:0]         r_in_list, n_in_list;
    logic [VALUE_BITS-1:0] r_mov_val, n_mov_val;
    logic [LB-1:0]         r_mov_list, n_mov_list;
    logic [VALUE_BITS-1:0] r_min_val, n_min_val;
    logic [LB-1:0]         r_min_list, n_min_list;
    logic                  r_empty, n_empty;
    logic                  r_ovf, n_ovf;
    logic [IW-1:0]         r_hole, n_hole;
    logic                  r_ovalid, n_ovalid;
    logic [kmh_pkg::RESULT_BITS-1:0] r_o_min_value;
    logic [LB-1:0]         r_o_min_list;
    logic                  r_o_empty;
    logic                  r_o_ovf;
    logic [CW-1:0]         r_o_count;
    logic                  load_out;

    // memory port
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr0, mem_raddr1;
    logic [EW-1:0] mem_rdata0, mem_rdata1;

    logic [VALUE_BITS-1:0] rd0_val, rd1_val, best_val;
    logic [LB-1:0]         rd0_list, rd1_list, best_list;
    logic [XW-1:0]         c_x, c1_x;
    logic                  c_ok, c1_ok;
    logic                  c_first, c1_first, mov_first;
    logic [IW-1:0]         par;
    logic [3:0]            after_pop;
    logic                  sel_c, sel_c1;

    assign rd0_val  = mem_rdata0[EW-1:LB];
    assign rd0_list = mem_rdata0[LB-1:0];
    assign rd1_val  = mem_rdata1[EW-1:LB];
    assign rd1_list = mem_rdata1[LB-1:0];

    assign c_x   = {1'b0, r_hole, 1'b1};
    assign c1_x  = c_x + XW'(1);
    assign c_ok  = c_x < XW'(r_cnt);
    assign c1_ok = c1_x < XW'(r_cnt);
    assign par   = (r_hole - IW'(1)) >> 1;

    assign after_pop = (r_op == kmh_pkg::OP_REPL) ? S_PUSH : S_DONE;

    kmh_mem #(
        .DEPTH (LISTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wdata  (mem_wdata),
        .i_raddr0 (mem_raddr0),
        .i_raddr1 (mem_raddr1),
        .o_rdata0 (mem_rdata0),
        .o_rdata1 (mem_rdata1)
    );

    // left child against the moving entry
    kmh_order #(.VALUE_BITS(VALUE_BITS)) u_ord_c (
        .i_a_value (rd0_val),
        .i_a_list  (rd0_list),
        .i_b_value (r_mov_val),
        .i_b_list  (r_mov_list),
        .o_a_first (c_first)
    );

    assign best_val  = (c_ok && c_first) ? rd0_val  : r_mov_val;
    assign best_list = (c_ok && c_first) ? rd0_list : r_mov_list;

    // right child against the better of the two above
    kmh_order #(.VALUE_BITS(VALUE_BITS)) u_ord_c1 (
        .i_a_value (rd1_val),
        .i_a_list  (rd1_list),
        .i_b_value (best_val),
        .i_b_list  (best_list),
        .o_a_first (c1_first)
    );

    // moving entry against its parent on the way up
    kmh_order #(.VALUE_BITS(VALUE_BITS)) u_ord_up (
        .i_a_value (r_mov_val),
        .i_a_list  (r_mov_list),
        .i_b_value (rd0_val),
        .i_b_list  (rd0_list),
        .o_a_first (mov_first)
    );

    assign sel_c1 = c1_ok && c1_first;
    assign sel_c  = !sel_c1 && c_ok && c_first;

    assign o_ready  = (r_state == S_IDLE);
    assign load_out = (r_state == S_DONE) && (!r_ovalid || i_ready);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_in_val   = r_in_val;
        n_in_list  = r_in_list;
        n_mov_val  = r_mov_val;
        n_mov_list = r_mov_list;
        n_min_val  = r_min_val;
        n_min_list = r_min_list;
        n_empty    = r_empty;
        n_ovf      = r_ovf;
        n_hole     = r_hole;
        mem_we     = 1'b0;
        mem_waddr  = r_hole;
        mem_wdata  = {r_mov_val, r_mov_list};
        mem_raddr0 = c_x[IW-1:0];
        mem_raddr1 = c1_x[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op       = i_op;
                    n_in_val   = i_value;
                    n_in_list  = i_list_id;
                    n_min_val  = '0;
                    n_min_list = '0;
                    n_empty    = 1'b0;
                    n_ovf      = 1'b0;
                    case (i_op) inside
                        kmh_pkg::OP_POP, kmh_pkg::OP_REPL: begin
                            if (r_cnt == '0) begin
                                n_empty = 1'b1;
                                n_state = (i_op == kmh_pkg::OP_REPL) ? S_PUSH : S_DONE;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        kmh_pkg::OP_PUSH: n_state = S_PUSH;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_POP_RD: begin
                mem_raddr0 = '0;
                mem_raddr1 = IW'(r_cnt - CW'(1));
                n_state    = S_POP_LD;
            end
            S_POP_LD: begin
                // root is the result, last entry starts down from the root
                n_min_val  = rd0_val;
                n_min_list = rd0_list;
                n_mov_val  = rd1_val;
                n_mov_list = rd1_list;
                n_cnt      = r_cnt - CW'(1);
                n_hole     = '0;
                n_state    = (r_cnt == CW'(1)) ? after_pop : S_SD_RD;
            end
            S_SD_RD: begin
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                mem_we = 1'b1;
                if (sel_c1) begin
                    mem_wdata = mem_rdata1;
                    n_hole    = c1_x[IW-1:0];
                    n_state   = S_SD_RD;
                end else if (sel_c) begin
                    mem_wdata = mem_rdata0;
                    n_hole    = c_x[IW-1:0];
                    n_state   = S_SD_RD;
                end else begin
                    n_state = after_pop;
                end
            end
            S_PUSH: begin
                if (r_cnt >= CW'(LISTS)) begin
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_hole     = IW'(r_cnt);
                    n_cnt      = r_cnt + CW'(1);
                    n_mov_val  = r_in_val;
                    n_mov_list = r_in_list;
                    n_state    = (r_cnt == '0) ? S_PUT : S_SU_RD;
                end
            end
            S_SU_RD: begin
                mem_raddr0 = par;
                n_state    = S_SU_CMP;
            end
            S_SU_CMP: begin
                mem_we = 1'b1;
                if (mov_first) begin
                    // parent moves down into the hole
                    mem_wdata = mem_rdata0;
                    n_hole    = par;
                    n_state   = (par == '0) ? S_PUT : S_SU_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_in_val   <= n_in_val;
        r_in_list  <= n_in_list;
        r_mov_val  <= n_mov_val;
        r_mov_list <= n_mov_list;
        r_min_val  <= n_min_val;
        r_min_list <= n_min_list;
        r_empty    <= n_empty;
        r_ovf      <= n_ovf;
        r_hole     <= n_hole;
        if (load_out) begin
            // stored bits zero-extended or cut to the result width
            r_o_min_value <= kmh_pkg::RESULT_BITS'(r_min_val);
            r_o_min_list  <= r_min_list;
            r_o_empty     <= r_empty;
            r_o_ovf       <= r_ovf;
            r_o_count     <= r_cnt;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_min_value = r_o_min_value;
    assign o_min_list  = r_o_min_list;
    assign o_was_empty = r_o_empty;
    assign o_overflow  = r_o_ovf;
    assign o_count     = r_o_count;

    `KMH_ASSERT_ALWAYS(a_cnt_bound, r_cnt <= CW'(LISTS), "entry count above capacity")
    `KMH_ASSERT_IMPLY(a_write_in_heap, mem_we, CW'(mem_waddr) < r_cnt,
        "heap write outside held entries")
    `KMH_ASSERT_IMPLY(a_flags_exclusive, o_valid, !(o_was_empty && o_overflow),
        "result flags empty and overflow together")
    `KMH_ASSERT_IMPLY(a_ovf_full, o_valid && o_overflow, o_count == CW'(LISTS),
        "overflow reported with room left")
    `KMH_ASSERT_IMPLY(a_pop_nonempty, r_state == S_POP_LD, r_cnt != '0,
        "pop started on an empty heap")

endmodule

`default_nettype wire

/* tb/sv/kway_merge_min_heap_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the k-way merge min-heap: watches both valid/ready channels, keeps its own
// heap of (value, list) entries and compares every result transfer field by field.
// Depends on kmh_pkg for the operation codes.

module kway_merge_min_heap_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  kmh_pkg::t_op        i_op,
    input  logic signed [31:0]  i_value,
    input  logic [3:0]          i_list_id,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic signed [31:0]  i_min_value,
    input  logic [3:0]          i_min_list,
    input  logic                i_was_empty,
    input  logic                i_overflow,
    input  logic [4:0]          i_count,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int HEAP_DEPTH = 16;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [3:0]         min_list;
        logic               was_empty;
        logic               overflow;
        logic [4:0]         count;
    } t_heap_result;

    logic signed [31:0] slot_value [HEAP_DEPTH];
    logic [3:0]         slot_list  [HEAP_DEPTH];
    int                 held;
    t_heap_result       result_q [$];
    int                 fail_count;

    // ordering: smaller value first, ties to the smaller list number
    function automatic logic comes_first(logic signed [31:0] va, logic [3:0] la,
                                         logic signed [31:0] vb, logic [3:0] lb);
        if (va != vb)
            return va < vb;
        return la < lb;
    endfunction

    function void swap_slots(int a, int b);
        logic signed [31:0] tv;
        logic [3:0]         tl;
        tv            = slot_value[a];
        tl            = slot_list[a];
        slot_value[a] = slot_value[b];
        slot_list[a]  = slot_list[b];
        slot_value[b] = tv;
        slot_list[b]  = tl;
    endfunction

    function t_heap_result heap_apply(kmh_pkg::t_op op, logic signed [31:0] value,
                                      logic [3:0] lid);
        t_heap_result r;
        int i, p, c, best;
        r = '0;
        if (op == kmh_pkg::OP_POP || op == kmh_pkg::OP_REPL) begin
            if (held == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.min_value   = slot_value[0];
                r.min_list    = slot_list[0];
                held          = held - 1;
                slot_value[0] = slot_value[held];
                slot_list[0]  = slot_list[held];
                i = 0;
                while (1) begin
                    c    = 2 * i + 1;
                    best = i;
                    if (c < held && comes_first(slot_value[c], slot_list[c],
                                                slot_value[best], slot_list[best]))
                        best = c;
                    if (c + 1 < held && comes_first(slot_value[c+1], slot_list[c+1],
                                                    slot_value[best], slot_list[best]))
                        best = c + 1;
                    if (best == i)
                        break;
                    swap_slots(i, best);
                    i = best;
                end
            end
        end
        if (op == kmh_pkg::OP_PUSH || op == kmh_pkg::OP_REPL) begin
            if (held >= HEAP_DEPTH) begin
                r.overflow = 1'b1;
            end else begin
                i             = held;
                slot_value[i] = value;
                slot_list[i]  = lid;
                held          = held + 1;
                while (i > 0) begin
                    p = (i - 1) / 2;
                    if (!comes_first(slot_value[i], slot_list[i], slot_value[p], slot_list[p]))
                        break;
                    swap_slots(i, p);
                    i = p;
                end
            end
        end
        r.count = held[4:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result seen, want;
        if (!i_rst_n) begin
            held = 0;
            result_q.delete();
        end else begin
            // result side first, so a result never matches an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                seen = '{i_min_value, i_min_list, i_was_empty, i_overflow, i_count};
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result transfer with nothing outstanding: %0d %0d %0b %0b %0d",
                                 $realtime, seen.min_value, seen.min_list, seen.was_empty,
                                 seen.overflow, seen.count);
                end else begin
                    want = result_q.pop_front();
                    if (seen.min_value !== want.min_value || seen.min_list !== want.min_list ||
                        seen.was_empty !== want.was_empty || seen.overflow !== want.overflow ||
                        seen.count !== want.count) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("%0t: mismatch exp value=%0d list=%0d empty=%0b ovf=%0b count=%0d",
                                     $realtime, want.min_value, want.min_list,
                                     want.was_empty, want.overflow, want.count);
                            $display("    got value=%0d list=%0d empty=%0b ovf=%0b count=%0d",
                                     seen.min_value, seen.min_list, seen.was_empty,
                                     seen.overflow, seen.count);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                result_q.insert(result_q.size(), heap_apply(i_op, i_value, i_list_id));
        end
        o_pending    <= result_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/sv/kway_merge_min_heap_tb.sv */
`timescale 1ns / 1ps
// Top of the k-way merge min-heap testbench: clock, reset, operation stimulus and verdict.
// Depends on kmh_pkg, kway_merge_min_heap and kway_merge_min_heap_checker.

module kway_merge_min_heap_tb;

    localparam int           HEAP_DEPTH     = 16;
    localparam int           ITEM_TARGET    = 1650;
    localparam int           WATCHDOG_LIMIT = 1000;
    localparam int           DRAIN_CYCLES   = 40;
    localparam kmh_pkg::t_op OP_UNUSED      = 2'd3;

    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         i_valid   = 1'b0;
    kmh_pkg::t_op i_op      = kmh_pkg::OP_PUSH;
    logic [31:0]  i_value   = '0;
    logic [3:0]   i_list_id = '0;
    logic         i_ready   = 1'b0;
    logic         o_ready;
    logic         o_valid;
    logic signed [31:0] o_min_value;
    logic [3:0]   o_min_list;
    logic         o_was_empty;
    logic         o_overflow;
    logic [4:0]   o_count;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    logic idle_on = 1'b0;
    int   fill    = 0;
    int   n_items = 0;
    int   n_push = 0, n_pop = 0, n_repl = 0, n_unused = 0;
    int   n_full_push = 0, n_empty_pop = 0, n_pauses = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    kway_merge_min_heap #(
        .LISTS      (HEAP_DEPTH),
        .VALUE_BITS (32)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_list_id   (i_list_id),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_min_value (o_min_value),
        .o_min_list  (o_min_list),
        .o_was_empty (o_was_empty),
        .o_overflow  (o_overflow),
        .o_count     (o_count)
    );

    kway_merge_min_heap_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_list_id    (i_list_id),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_min_value  (o_min_value),
        .i_min_list   (o_min_list),
        .i_was_empty  (o_was_empty),
        .i_overflow   (o_overflow),
        .i_count      (o_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: each result gets its own stall, counted only while it is offered
    logic result_taken = 1'b0;
    int   result_hold  = 0;

    always @(posedge i_clk) begin
        result_taken <= i_rst_n && o_valid && i_ready;
    end

    always @(negedge i_clk) begin
        if (result_taken)
            result_hold = idle_on ? $urandom_range(0, 5) : 0;
        if (result_hold > 0 && o_valid) begin
            result_hold--;
            i_ready = 1'b0;
        end else if (result_hold > 0) begin
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either channel
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("[kway_merge_min_heap] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8) - 4;    // narrow range, plenty of ties
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer, valid still high
    task automatic send_op(kmh_pkg::t_op op, logic [31:0] value, logic [3:0] lid);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_op      = op;
        i_value   = value;
        i_list_id = lid;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        case (op)
            kmh_pkg::OP_PUSH: begin
                n_push++;
                if (fill < HEAP_DEPTH) fill++;
                else n_full_push++;
            end
            kmh_pkg::OP_POP: begin
                n_pop++;
                if (fill > 0) fill--;
                else n_empty_pop++;
            end
            kmh_pkg::OP_REPL: begin
                n_repl++;
                if (fill == 0) begin
                    n_empty_pop++;
                    fill++;
                end
            end
            default: n_unused++;
        endcase
        if (op != OP_UNUSED)
            n_items++;
    endtask

    task automatic wait_all_results();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        n_pauses++;
    endtask

    initial begin
        int target, extra;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty queue, extremes, tie order, full queue, unused opcode
        send_op(kmh_pkg::OP_POP,  32'h0, 4'd0);
        send_op(kmh_pkg::OP_REPL, 32'h7fff_ffff, 4'd15);
        send_op(OP_UNUSED, $urandom(), 4'($urandom_range(0, 15)));
        send_op(kmh_pkg::OP_POP,  32'h0, 4'd0);
        send_op(kmh_pkg::OP_PUSH, 32'h8000_0000, 4'd0);
        send_op(kmh_pkg::OP_PUSH, 32'h7fff_ffff, 4'd15);
        send_op(kmh_pkg::OP_PUSH, 32'h0, 4'd5);
        send_op(kmh_pkg::OP_PUSH, 32'hffff_ffff, 4'd10);
        send_op(kmh_pkg::OP_PUSH, 32'd5, 4'd9);
        send_op(kmh_pkg::OP_PUSH, 32'd5, 4'd3);
        while (fill < HEAP_DEPTH)
            send_op(kmh_pkg::OP_PUSH, rand_value(), 4'($urandom_range(0, 15)));
        send_op(kmh_pkg::OP_PUSH, 32'h8000_0000, 4'd0);
        send_op(kmh_pkg::OP_REPL, 32'h8000_0000, 4'd15);
        send_op(OP_UNUSED, 32'hffff_ffff, 4'd15);
        wait_all_results();

        // random merge-like episodes: load heads, churn mostly with replaces, then drain in most episodes
        while (n_items < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                wait_all_results();
            target = $urandom_range(1, HEAP_DEPTH);
            while (fill < target)
                send_op(kmh_pkg::OP_PUSH, rand_value(), 4'($urandom_range(0, 15)));
            if (fill == HEAP_DEPTH && $urandom_range(0, 3) == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra)
                    send_op(kmh_pkg::OP_PUSH, rand_value(), 4'($urandom_range(0, 15)));
            end
            repeat ($urandom_range(4, 40)) begin
                case ($urandom_range(0, 19))
                    0:                       send_op(OP_UNUSED, $urandom(),
                                                     4'($urandom_range(0, 15)));
                    1, 2, 3, 4, 5, 6,
                    7, 8, 9, 10, 11, 12:     send_op(kmh_pkg::OP_REPL, rand_value(),
                                                     4'($urandom_range(0, 15)));
                    13, 14, 15, 16:          send_op(kmh_pkg::OP_PUSH, rand_value(),
                                                     4'($urandom_range(0, 15)));
                    default:                 send_op(kmh_pkg::OP_POP, rand_value(),
                                                     4'($urandom_range(0, 15)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                while (fill > 0)
                    send_op(kmh_pkg::OP_POP, rand_value(), 4'($urandom_range(0, 15)));
                if ($urandom_range(0, 1) == 0)
                    send_op(kmh_pkg::OP_POP, rand_value(), 4'($urandom_range(0, 15)));
            end
        end

        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d operations: %0d pushes, %0d pops, %0d replaces, %0d unused opcodes.",
                 n_items + n_unused, n_push, n_pop, n_repl, n_unused);
        $display("Pushes when full: %0d, removals when empty: %0d, drain pauses: %0d.",
                 n_full_push, n_empty_pop, n_pauses);
        if (fail_count == 0 && pending == 0) begin
            $display("[kway_merge_min_heap] OK");
        end else begin
            $display("%0d failed result checks, %0d results outstanding", fail_count, pending);
            $display("[kway_merge_min_heap] ERROR");
        end
        $finish;
    end

endmodule
